// ----- rtl/core/assert_macros.svh -----
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion, disabled while reset is asserted.
`define STQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Clocked assertion, checked during reset too.
`define STQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`endif

// ----- rtl/core/stq_pkg.sv -----
// ----------------------------------------------------------------------------
// stq_pkg
// Types and constants of the sorted timer queue.
// ----------------------------------------------------------------------------
package stq_pkg;
  localparam int Capacity = 64;
  localparam int TimeBits = 32;
  localparam int IdBits   = 16;
  localparam int CntBits  = $clog2(Capacity + 1);

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_ADJUST = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_EXPIRED   = 3'd4,
    ST_NONE_DUE  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    OP_NOP    = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_POP    = 2'd3
  } op_e;

  typedef struct packed {
    logic load;
    op_e  op;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e              cmd;
    logic              found;
    logic              full;
    logic              head_due;
    logic              next_due;
    logic [IdBits-1:0] head_id;
    logic [IdBits-1:0] in_id;
    logic [CntBits-1:0] count;
  } dp_status_t;
endpackage

// ----- rtl/core/stq_cells.sv -----
// ----------------------------------------------------------------------------
// stq_cells
// Cell chain datapath: sorted entries, operand latch, per-cell compares.
// ----------------------------------------------------------------------------
module stq_cells import stq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_e                command_i,
  input  logic [IdBits-1:0]   timer_id_i,
  input  logic [TimeBits-1:0] expire_time_i,
  input  logic [TimeBits-1:0] now_time_i,
  input  dp_cmd_t             cmd_i,
  output dp_status_t          status_o
);
  logic [TimeBits-1:0] cell_exp_q [Capacity];
  logic [IdBits-1:0]   cell_id_q  [Capacity];
  logic [CntBits-1:0]  count_q, count_d;
  cmd_e                in_cmd_q;
  logic [IdBits-1:0]   in_id_q;
  logic [TimeBits-1:0] in_exp_q, in_now_q;

  logic [Capacity-1:0] valid, le_v, le_prev, match, match_pre;
  logic [TimeBits-1:0] prev_exp [Capacity];
  logic [IdBits-1:0]   prev_id  [Capacity];
  logic [TimeBits-1:0] next_exp [Capacity];
  logic [IdBits-1:0]   next_id  [Capacity];

  always_comb begin
    for (int i = 0; i < Capacity; i++) begin
      valid[i] = CntBits'(i) < count_q;
      le_v[i]  = valid[i] && (cell_exp_q[i] <= in_exp_q);
      match[i] = valid[i] && (cell_id_q[i] == in_id_q);
    end
    for (int i = 0; i < Capacity; i++) begin
      match_pre[i] = |(match & ({Capacity{1'b1}} >> (Capacity - 1 - i)));
    end
    le_prev[0]  = 1'b1;
    prev_exp[0] = in_exp_q;
    prev_id[0]  = in_id_q;
    for (int i = 1; i < Capacity; i++) begin
      le_prev[i]  = le_v[i-1];
      prev_exp[i] = cell_exp_q[i-1];
      prev_id[i]  = cell_id_q[i-1];
    end
    for (int i = 0; i < Capacity - 1; i++) begin
      next_exp[i] = cell_exp_q[i+1];
      next_id[i]  = cell_id_q[i+1];
    end
    next_exp[Capacity-1] = cell_exp_q[Capacity-1];
    next_id[Capacity-1]  = cell_id_q[Capacity-1];
  end

  always_comb begin
    count_d = count_q;
    case (cmd_i.op) inside
      OP_INSERT:        count_d = count_q + 1'b1;
      OP_REMOVE, OP_POP: count_d = count_q - 1'b1;
      default:          count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      in_cmd_q <= CMD_ADD;
    end else begin
      count_q <= count_d;
      if (cmd_i.load) in_cmd_q <= command_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_id_q  <= timer_id_i;
      in_exp_q <= expire_time_i;
      in_now_q <= now_time_i;
    end
    for (int i = 0; i < Capacity; i++) begin
      case (cmd_i.op)
        OP_INSERT: begin
          if (!le_v[i]) begin
            if (le_prev[i]) begin
              cell_exp_q[i] <= in_exp_q;
              cell_id_q[i]  <= in_id_q;
            end else begin
              cell_exp_q[i] <= prev_exp[i];
              cell_id_q[i]  <= prev_id[i];
            end
          end
        end
        OP_REMOVE: begin
          if (match_pre[i]) begin
            cell_exp_q[i] <= next_exp[i];
            cell_id_q[i]  <= next_id[i];
          end
        end
        OP_POP: begin
          cell_exp_q[i] <= next_exp[i];
          cell_id_q[i]  <= next_id[i];
        end
        default: ;
      endcase
    end
  end

  assign status_o.cmd      = in_cmd_q;
  assign status_o.found    = |match;
  assign status_o.full     = count_q == CntBits'(Capacity);
  assign status_o.head_due = valid[0] && (cell_exp_q[0] <= in_now_q);
  assign status_o.next_due = valid[1] && (cell_exp_q[1] <= in_now_q);
  assign status_o.head_id  = cell_id_q[0];
  assign status_o.in_id    = in_id_q;
  assign status_o.count    = count_q;
endmodule

// ----- rtl/core/stq_ctrl.sv -----
// ----------------------------------------------------------------------------
// stq_ctrl
// Command sequencer and registered result port.
// ----------------------------------------------------------------------------
module stq_ctrl import stq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  dp_status_t        status_i,
  output dp_cmd_t           cmd_o,
  output logic              valid_o,
  output status_e           status_o,
  output logic [IdBits-1:0] expired_id_o,
  output logic              last_o
);
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DECIDE = 4'b0010,
    S_REINS  = 4'b0100,
    S_TICK   = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic              valid_q, valid_d, last_q, last_d;
  status_e           res_q, res_d;
  logic [IdBits-1:0] rid_q, rid_d;

  // pop one due timer, last when the next one is not due
  function automatic void tick_step(output op_e op, output status_e st, output logic lst);
    op  = OP_POP;
    st  = ST_EXPIRED;
    lst = !status_i.next_due;
  endfunction

  always_comb begin
    op_e     op;
    status_e st;
    logic    lst;
    state_d   = state_q;
    cmd_o     = '{load: 1'b0, op: OP_NOP};
    valid_d   = 1'b0;
    res_d     = res_q;
    rid_d     = status_i.in_id;
    last_d    = 1'b1;
    op = OP_NOP; st = ST_OK; lst = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        valid_d = 1'b1;
        state_d = S_IDLE;
        case (status_i.cmd) inside
          CMD_ADD: begin
            if (status_i.found)      res_d = ST_DUPLICATE;
            else if (status_i.full)  res_d = ST_FULL;
            else begin
              res_d     = ST_OK;
              cmd_o.op  = OP_INSERT;
            end
          end
          CMD_ADJUST, CMD_DELETE: begin
            if (!status_i.found) res_d = ST_NOT_FOUND;
            else begin
              res_d    = ST_OK;
              cmd_o.op = OP_REMOVE;
              if (status_i.cmd == CMD_ADJUST) begin
                valid_d = 1'b0;
                state_d = S_REINS;
              end
            end
          end
          default: begin
            if (!status_i.head_due) begin
              res_d = ST_NONE_DUE;
              rid_d = '0;
            end else begin
              tick_step(op, st, lst);
              cmd_o.op = op;
              res_d    = st;
              last_d   = lst;
              rid_d    = status_i.head_id;
              if (!lst) state_d = S_TICK;
            end
          end
        endcase
      end
      S_REINS: begin
        valid_d  = 1'b1;
        res_d    = ST_OK;
        cmd_o.op = OP_INSERT;
        state_d  = S_IDLE;
      end
      S_TICK: begin
        tick_step(op, st, lst);
        valid_d  = 1'b1;
        cmd_o.op = op;
        res_d    = st;
        last_d   = lst;
        rid_d    = status_i.head_id;
        if (lst) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    rid_q  <= rid_d;
    last_q <= last_d;
  end

  assign busy         = state_q != S_IDLE;
  assign valid_o      = valid_q;
  assign status_o     = res_q;
  assign expired_id_o = rid_q;
  assign last_o       = last_q;
endmodule

// ----- rtl/core/sorted_timer_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_timer_queue
// Up to 64 timers kept sorted by expiry in a register cell chain.
// ----------------------------------------------------------------------------
// A command transfers when start is high and busy is low. Each result shows
// on status_o/expired_id_o/last_o for exactly one cycle with valid_o high;
// the receiver cannot stall it. Add and delete load the operands, then decide;
// adjust also reinserts after the remove, and a tick pops its expired timers
// one by one after the load. The sequencer applies one shift of the whole cell
// chain per cycle. Results are registered and appear in the cycle after the
// state that made them; after the last one the block is already ready again.
`include "assert_macros.svh"
module sorted_timer_queue import stq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          command_i,
  input  logic [IdBits-1:0]   timer_id_i,
  input  logic [TimeBits-1:0] expire_time_i,
  input  logic [TimeBits-1:0] now_time_i,
  output logic                valid_o,
  output logic [2:0]          status_o,
  output logic [IdBits-1:0]   expired_id_o,
  output logic                last_o
);
  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;
  status_e    res;

  // datapath: entries, operand latch, parallel compares
  stq_cells u_cells (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .command_i     (cmd_e'(command_i)),
    .timer_id_i    (timer_id_i),
    .expire_time_i (expire_time_i),
    .now_time_i    (now_time_i),
    .cmd_i         (dp_cmd),
    .status_o      (dp_status)
  );

  // sequencer and result register
  stq_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .status_i     (dp_status),
    .cmd_o        (dp_cmd),
    .valid_o      (valid_o),
    .status_o     (res),
    .expired_id_o (expired_id_o),
    .last_o       (last_o)
  );

  assign status_o = res;

  `STQ_ASSERT(a_busy_after_start, start && !busy |=> busy, "no busy after transfer")
  `STQ_ASSERT(a_count_range, dp_status.count <= CntBits'(Capacity), "count overflow")
  `STQ_ASSERT(a_none_due, valid_o && res == ST_NONE_DUE |-> last_o && expired_id_o == '0, "bad none due")
  `STQ_ASSERT(a_not_last, valid_o && !last_o |-> res == ST_EXPIRED, "non-final result not expired")
endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sorted_timer_queue: commands go in through the
// start/busy handshake, a scoreboard keeps its own sorted timer list and
// checks every strobed result in order.
// ----------------------------------------------------------------------------
module tb_top;
  import stq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // One expected result of a command.
  typedef struct {
    status_e           status;
    logic [IdBits-1:0] ident;
    logic              last;
  } timer_result_t;

  // Scoreboard: shadow copy of the sorted list and the queue of results
  // still to come from the block.
  class timer_scoreboard;
    logic [TimeBits-1:0] expiry_q[$];
    logic [IdBits-1:0]   ident_q[$];
    timer_result_t       pending_q[$];
    int                  errors;

    function int find_timer(logic [IdBits-1:0] id);
      foreach (ident_q[i]) if (ident_q[i] == id) return i;
      return -1;
    endfunction

    // Insert behind every timer with an expiry at or before the new one.
    function void insert_timer(logic [IdBits-1:0] id, logic [TimeBits-1:0] exp);
      int pos;
      pos = 0;
      while (pos < expiry_q.size() && expiry_q[pos] <= exp) pos++;
      expiry_q.insert(pos, exp);
      ident_q.insert(pos, id);
    endfunction

    function void push(status_e st, logic [IdBits-1:0] id, logic lst);
      timer_result_t r;
      r.status = st;
      r.ident  = id;
      r.last   = lst;
      pending_q.push_back(r);
    endfunction

    // Note an accepted command and predict its results.
    function void note_command(cmd_e cmd, logic [IdBits-1:0] id,
                               logic [TimeBits-1:0] exp, logic [TimeBits-1:0] now);
      int pos;
      int n;
      case (cmd)
        CMD_ADD: begin
          if (find_timer(id) >= 0) push(ST_DUPLICATE, id, 1'b1);
          else if (ident_q.size() >= Capacity) push(ST_FULL, id, 1'b1);
          else begin
            insert_timer(id, exp);
            push(ST_OK, id, 1'b1);
          end
        end
        CMD_ADJUST, CMD_DELETE: begin
          pos = find_timer(id);
          if (pos < 0) push(ST_NOT_FOUND, id, 1'b1);
          else begin
            expiry_q.delete(pos);
            ident_q.delete(pos);
            if (cmd == CMD_ADJUST) insert_timer(id, exp);
            push(ST_OK, id, 1'b1);
          end
        end
        default: begin
          n = 0;
          while (expiry_q.size() > 0 && expiry_q[0] <= now) begin
            push(ST_EXPIRED, ident_q[0], 1'b0);
            void'(expiry_q.pop_front());
            void'(ident_q.pop_front());
            n++;
          end
          if (n == 0) push(ST_NONE_DUE, '0, 1'b1);
          else pending_q[pending_q.size()-1].last = 1'b1;
        end
      endcase
    endfunction

    // Compare one strobed result with the oldest expectation.
    function void check_result(logic [2:0] st, logic [IdBits-1:0] id, logic lst);
      timer_result_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result status=%0d id=%h last=%b", $time, st, id, lst);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (st != e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, st);
        errors++;
      end
      if (id != e.ident) begin
        $display("%0t: expired_id expected %h actual %h", $time, e.ident, id);
        errors++;
      end
      if (lst != e.last) begin
        $display("%0t: last expected %b actual %b", $time, e.last, lst);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [1:0]          command_i;
  logic [IdBits-1:0]   timer_id_i;
  logic [TimeBits-1:0] expire_time_i;
  logic [TimeBits-1:0] now_time_i;
  logic                valid_o;
  logic [2:0]          status_o;
  logic [IdBits-1:0]   expired_id_o;
  logic                last_o;

  timer_scoreboard sb;
  int              cycle_cnt;
  bit              idle_en;     // random gaps between transfers
  int              sent_cnt;

  sorted_timer_queue dut (
    .clk_i, .rst_ni, .start, .busy, .command_i, .timer_id_i, .expire_time_i,
    .now_time_i, .valid_o, .status_o, .expired_id_o, .last_o
  );

  always begin
    clk_i = 1'b0; #5;
    clk_i = 1'b1; #5;
  end

  // Results cannot be held off, so every strobe is checked at the edge.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) sb.check_result(status_o, expired_id_o, last_o);
  end

  // Watchdog: stops the run with FAIL once the cycle counter passes its limit.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 200000) begin
      $display("FAIL");
      $finish;
    end
  end

  // Issue one command; holds start until the transfer edge.
  task automatic send_cmd(cmd_e cmd, logic [IdBits-1:0] id,
                          logic [TimeBits-1:0] exp, logic [TimeBits-1:0] now);
    int gap;
    if (idle_en && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 10);
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start         <= 1'b1;
    command_i     <= cmd;
    timer_id_i    <= id;
    expire_time_i <= exp;
    now_time_i    <= now;
    do @(posedge clk_i); while (busy);
    sb.note_command(cmd, id, exp, now);
    sent_cnt++;
    @(negedge clk_i);
  endtask

  // Hold off until every predicted result has been seen.
  task automatic drain();
    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Mostly a small id pool so adjust/delete/duplicate hit live timers.
  function automatic logic [IdBits-1:0] pick_id();
    if ($urandom_range(0, 9) == 0) return IdBits'($urandom);
    if ($urandom_range(0, 3) == 0 && sb.ident_q.size() > 0)
      return sb.ident_q[$urandom_range(0, sb.ident_q.size() - 1)];
    return IdBits'($urandom_range(0, 95));
  endfunction

  // Expiries near a moving time base so ticks expire a few at a time.
  function automatic logic [TimeBits-1:0] pick_time(logic [TimeBits-1:0] base);
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return '1;
      default: return base + $urandom_range(0, 400);
    endcase
  endfunction

  initial begin
    logic [TimeBits-1:0] tbase;
    cmd_e                c;
    int                  r;
    sb            = new();
    cycle_cnt     = 0;
    idle_en       = 1'b0;
    sent_cnt      = 0;
    rst_ni        = 1'b0;
    start         = 1'b0;
    command_i     = CMD_ADD;
    timer_id_i    = '0;
    expire_time_i = '0;
    now_time_i    = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty-list cases, extremes, ties, moves both ways.
    send_cmd(CMD_TICK,   '0,      '0,       '1);   // nothing due
    send_cmd(CMD_DELETE, 16'h1,   '0,       '0);   // not found
    send_cmd(CMD_ADJUST, '1,      '0,       '0);   // not found
    send_cmd(CMD_ADD,    '1,      '1,       '0);
    send_cmd(CMD_ADD,    '0,      '0,       '0);   // new head
    send_cmd(CMD_ADD,    16'h5,   32'd100,  '0);
    send_cmd(CMD_ADD,    16'h6,   32'd100,  '0);   // tie goes behind
    send_cmd(CMD_ADD,    16'h5,   32'd7,    '0);   // duplicate
    send_cmd(CMD_ADJUST, 16'h6,   32'd1,    '0);   // move earlier
    send_cmd(CMD_ADJUST, '0,      32'd100,  '0);   // move later, behind tie
    send_cmd(CMD_ADJUST, 16'h5,   32'd100,  '0);   // same expiry
    send_cmd(CMD_TICK,   '0,      '0,       32'd0);
    send_cmd(CMD_TICK,   '0,      '0,       32'd100);
    send_cmd(CMD_DELETE, '1,      '0,       '0);
    send_cmd(CMD_TICK,   '0,      '0,       '1);
    // Fill to capacity, hit full and duplicate-at-full, then flush all 64.
    for (int i = 0; i < Capacity; i++)
      send_cmd(CMD_ADD, 16'(16'hA000 + i), 32'($urandom_range(0, 50)), '0);
    send_cmd(CMD_ADD, 16'hFFF0, 32'd3, '0);         // full
    send_cmd(CMD_ADD, 16'hA000, 32'd3, '0);         // duplicate beats full
    send_cmd(CMD_DELETE, 16'hA010, '0, '0);
    send_cmd(CMD_ADD, 16'hFFF0, '1, '0);
    send_cmd(CMD_TICK, '0, '0, '1);                 // all 64 expire
    drain();

    // Random: bursts of adds then ticks that march the time base forward.
    idle_en = 1'b1;
    tbase   = 32'd1000;
    while (sent_cnt < 270) begin
      if (sent_cnt > 235) idle_en = 1'b0;
      if (sent_cnt == 170) drain();
      r = $urandom_range(0, 99);
      if (r < 45) c = CMD_ADD;
      else if (r < 60) c = CMD_ADJUST;
      else if (r < 72) c = CMD_DELETE;
      else c = CMD_TICK;
      if (c == CMD_TICK) begin
        tbase = tbase + $urandom_range(0, 150);
        send_cmd(c, IdBits'($urandom), $urandom,
                 ($urandom_range(0, 19) == 0) ? $urandom : tbase);
      end else begin
        send_cmd(c, pick_id(), pick_time(tbase), $urandom);
      end
    end

    drain();
    repeat (20) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
